// ===== hdl/dram_frfcfs_scheduler_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DRAM_FRFCFS_SCHEDULER_ASSERT_SVH
`define DRAM_FRFCFS_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DFS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DFS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, codes and helpers of the FR-FCFS DRAM scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int ONGOING_DEPTH_DEF = 8;
    localparam int NUM_BANKS         = 8;
    localparam int BANK_W            = 3;
    localparam int BANK_LSB          = 5;
    localparam int TAG_W             = 32;
    localparam int WIN_W             = 34;   // cycle distance plus window offsets
    localparam int OFF_W             = 12;   // offsets relative to a request start

    // result kinds
    localparam logic [1:0] KIND_QUEUED    = 2'd0;
    localparam logic [1:0] KIND_DROPPED   = 2'd1;
    localparam logic [1:0] KIND_COMPLETED = 2'd2;
    localparam logic [1:0] KIND_SUMMARY   = 2'd3;

    // row buffer states
    localparam logic [1:0] RS_HIT  = 2'd0;
    localparam logic [1:0] RS_MISS = 2'd1;
    localparam logic [1:0] RS_CONF = 2'd2;

    // actions
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_CMD  = 2'd0;
    localparam logic [1:0] CFG_BANK = 2'd1;
    localparam logic [1:0] CFG_DATA = 2'd2;
    localparam logic [1:0] CFG_MASK = 2'd3;

    localparam logic [7:0]  CMD_RST  = 8'd3;
    localparam logic [9:0]  BANK_RST = 10'd99;
    localparam logic [9:0]  DATA_RST = 10'd49;
    localparam logic [31:0] MASK_RST = 32'hFFFF_FF00;

    typedef struct packed {
        logic             action;
        logic [TAG_W-1:0] tag;
    } dfs_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TAG_W-1:0]  tag_out;
        logic              scheduled;
        logic [1:0]        row_status;
        logic [BANK_W-1:0] bank_out;
        logic              last;
    } dfs_out_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [TAG_W-1:0] start;
        logic [1:0]       st;
    } dfs_ong_t;

    typedef struct packed {
        logic load;
        logic shift;
    } dfs_cell_ctl_t;

    function automatic logic [BANK_W-1:0] bank_of(input logic [TAG_W-1:0] t);
        return t[BANK_LSB +: BANK_W];
    endfunction

    // offset of the read/write phase from the request start
    function automatic logic [OFF_W-1:0] rw_off(input logic [1:0] st,
                                                input logic [10:0] p1);
        logic [OFF_W-1:0] r;
        r = '0;
        if (st >= 2'd2)      r = {p1, 1'b0};
        else if (st >= 2'd1) r = {1'b0, p1};
        return r;
    endfunction

    // offset of the last data burst cycle from the request start
    function automatic logic [OFF_W-1:0] data_end(input logic [1:0] st,
                                                  input logic [9:0] p,
                                                  input logic [9:0] d);
        logic [10:0] p1;
        p1 = {1'b0, p} + 11'd1;
        return rw_off(st, p1) + OFF_W'(p1) + OFF_W'(d);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dram_frfcfs_scheduler.sv =====
// ----------------------------------------------------------------------------
// dram_frfcfs_scheduler
// FR-FCFS DRAM request scheduler built on rows of queue cells.
// ----------------------------------------------------------------------------
// Use:
//   in_valid/in_stall/in_data carry items: action 0 queues the tag, action 1
//   is one scheduler tick. out_valid/out_stall/out_data return results; the
//   final result of an item has last set. cfg_valid/cfg_ready/cfg_index/
//   cfg_data write the timing registers and the row mask; write only idle.
// Timing:
//   An add gives its result in the cycle after its transfer, one item per
//   cycle while idle and the output drains. A tick walks the ongoing table
//   one slot a cycle, a retire waiting while the output is stalled. It then
//   scans pending entries against ongoing entries one pair a cycle (no scan
//   with a full ongoing table) and ends with the summary. The scan uses one
//   shared window compare unit.
// Reset:
//   Both queues empty, all bank rows closed, cycle count zero, registers at
//   their defaults. cfg_ready is always high.
// Stall:
//   Results sit in one output register; with out_stall high a retire or the
//   summary waits, and in_stall stays high until the register can refill.
// ----------------------------------------------------------------------------
`default_nettype none

module dram_frfcfs_scheduler #(
    parameter int PENDING_DEPTH = dfs_pkg::PENDING_DEPTH_DEF,
    parameter int ONGOING_DEPTH = dfs_pkg::ONGOING_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  dfs_pkg::dfs_in_t    in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output dfs_pkg::dfs_out_t   out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [31:0]          cfg_data
);
    import dfs_pkg::*;

    localparam int PW  = $clog2(PENDING_DEPTH);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int OW  = $clog2(ONGOING_DEPTH);
    localparam int OCW = $clog2(ONGOING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RET  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // control
    logic [1:0]       state_reg, state_next;
    logic [PCW-1:0]   pcnt_reg, pcnt_next;
    logic [OCW-1:0]   ocnt_reg, ocnt_next;
    logic [OCW-1:0]   oidx_reg, oidx_next;
    logic [PCW-1:0]   pidx_reg, pidx_next;
    logic [PW-1:0]    best_reg, best_next;
    logic             best_v_reg, best_v_next;
    logic [1:0]       best_st_reg, best_st_next;
    logic [TAG_W-1:0] cycle_reg, cycle_next;
    logic             out_valid_reg, out_valid_next;
    dfs_out_t         out_data_reg, out_data_next;

    // registers and bank state
    logic [7:0]       cmd_reg;
    logic [9:0]       phase_reg;
    logic [9:0]       data_reg;
    logic [31:0]      mask_reg;
    logic [TAG_W-1:0]     open_row_reg [NUM_BANKS];
    logic [NUM_BANKS-1:0] row_open_reg;

    // cell rows
    logic [TAG_W-1:0] pend_tag [PENDING_DEPTH];
    logic             pend_v   [PENDING_DEPTH];
    dfs_ong_t         ong_ent  [ONGOING_DEPTH];
    logic             ong_v    [ONGOING_DEPTH];

    logic             pend_push, pend_rm, ong_push, ong_rm, bank_wr;
    logic             can_emit, in_xfer;
    dfs_ong_t         ong_new;
    dfs_ong_t         ret_ent;
    dfs_ong_t         scan_ent;
    logic [TAG_W-1:0] cand_tag;
    logic [BANK_W-1:0] cand_bank;
    logic [1:0]       cand_st;
    logic [TAG_W-1:0] best_tag;
    logic [TAG_W-1:0] age;
    logic             conf_hit;

    assign can_emit  = !out_valid_reg || !out_stall;
    assign in_stall  = !(state_reg == ST_IDLE && can_emit);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // pending row
    for (genvar i = 0; i < PENDING_DEPTH; i++)
    begin : g_pend
        dfs_cell_ctl_t    ctl;
        logic [TAG_W-1:0] nbr_tag;
        logic             nbr_valid;

        assign ctl.load  = pend_push && (pcnt_reg == PCW'(i));
        assign ctl.shift = pend_rm && (PW'(i) >= best_reg);

        if (i + 1 < PENDING_DEPTH)
        begin : g_nbr
            assign nbr_tag   = pend_tag[i+1];
            assign nbr_valid = pend_v[i+1];
        end
        else
        begin : g_end
            assign nbr_tag   = '0;
            assign nbr_valid = 1'b0;
        end

        dfs_pend_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load_tag  (in_data.tag),
            .nbr_tag   (nbr_tag),
            .nbr_valid (nbr_valid),
            .tag       (pend_tag[i]),
            .valid     (pend_v[i])
        );
    end

    // ongoing row
    for (genvar i = 0; i < ONGOING_DEPTH; i++)
    begin : g_ong
        dfs_cell_ctl_t ctl;
        dfs_ong_t      nbr_ent;
        logic          nbr_valid;

        assign ctl.load  = ong_push && (ocnt_reg == OCW'(i));
        assign ctl.shift = ong_rm && (OW'(i) >= oidx_reg[OW-1:0]);

        if (i + 1 < ONGOING_DEPTH)
        begin : g_nbr
            assign nbr_ent   = ong_ent[i+1];
            assign nbr_valid = ong_v[i+1];
        end
        else
        begin : g_end
            assign nbr_ent   = '0;
            assign nbr_valid = 1'b0;
        end

        dfs_ong_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load_ent  (ong_new),
            .nbr_ent   (nbr_ent),
            .nbr_valid (nbr_valid),
            .ent       (ong_ent[i]),
            .valid     (ong_v[i])
        );
    end

    // slot under the walk; indexes past the count are never used
    assign ret_ent   = ong_ent[oidx_reg[OW-1:0]];
    assign scan_ent  = ret_ent;
    assign cand_tag  = pend_tag[pidx_reg[PW-1:0]];
    assign cand_bank = bank_of(cand_tag);
    assign best_tag  = pend_tag[best_reg];
    assign age       = cycle_reg - ret_ent.start;

    always_comb
    begin
        if (!row_open_reg[cand_bank])
        begin
            cand_st = RS_MISS;
        end
        else if (open_row_reg[cand_bank] == (cand_tag & mask_reg))
        begin
            cand_st = RS_HIT;
        end
        else
        begin
            cand_st = RS_CONF;
        end
    end

    dfs_conflict u_conflict (
        .cmd_cycles   (cmd_reg),
        .phase_cycles (phase_reg),
        .data_cycles  (data_reg),
        .delta        (cycle_reg - scan_ent.start),
        .st_o         (scan_ent.st),
        .st_c         (cand_st),
        .same_bank    (bank_of(scan_ent.tag) == cand_bank),
        .hit          (conf_hit)
    );

    assign ong_new.tag   = best_tag;
    assign ong_new.start = cycle_reg;
    assign ong_new.st    = best_st_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pcnt_next      = pcnt_reg;
        ocnt_next      = ocnt_reg;
        oidx_next      = oidx_reg;
        pidx_next      = pidx_reg;
        best_next      = best_reg;
        best_v_next    = best_v_reg;
        best_st_next   = best_st_reg;
        cycle_next     = cycle_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pend_push      = 1'b0;
        pend_rm        = 1'b0;
        ong_push       = 1'b0;
        ong_rm         = 1'b0;
        bank_wr        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.action == ACT_ADD)
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next            = '0;
                        out_data_next.tag_out    = in_data.tag;
                        out_data_next.bank_out   = bank_of(in_data.tag);
                        out_data_next.last       = 1'b1;
                        if (pcnt_reg != PCW'(PENDING_DEPTH))
                        begin
                            pend_push          = 1'b1;
                            pcnt_next          = pcnt_reg + PCW'(1);
                            out_data_next.kind = KIND_QUEUED;
                        end
                        else
                        begin
                            out_data_next.kind = KIND_DROPPED;
                        end
                    end
                    else
                    begin
                        oidx_next  = '0;
                        state_next = ST_RET;
                    end
                end
            end
            ST_RET:
            begin
                if (oidx_reg == ocnt_reg)
                begin
                    oidx_next   = '0;
                    pidx_next   = '0;
                    best_v_next = 1'b0;
                    state_next  = (ocnt_reg == OCW'(ONGOING_DEPTH)) ? ST_FIN : ST_SCAN;
                end
                else if (TAG_W'(data_end(ret_ent.st, phase_reg, data_reg)) <= age)
                begin
                    if (can_emit)
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next          = '0;
                        out_data_next.kind     = KIND_COMPLETED;
                        out_data_next.tag_out  = ret_ent.tag;
                        out_data_next.bank_out = bank_of(ret_ent.tag);
                        ong_rm                 = 1'b1;
                        ocnt_next              = ocnt_reg - OCW'(1);
                    end
                end
                else
                begin
                    oidx_next = oidx_reg + OCW'(1);
                end
            end
            ST_SCAN:
            begin
                if (pidx_reg == pcnt_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (oidx_reg == ocnt_reg)
                begin
                    // candidate clears every ongoing request
                    if (cand_st == RS_HIT)
                    begin
                        best_next    = pidx_reg[PW-1:0];
                        best_st_next = RS_HIT;
                        best_v_next  = 1'b1;
                        state_next   = ST_FIN;
                    end
                    else
                    begin
                        if (!best_v_reg)
                        begin
                            best_next    = pidx_reg[PW-1:0];
                            best_st_next = cand_st;
                            best_v_next  = 1'b1;
                        end
                        pidx_next = pidx_reg + PCW'(1);
                        oidx_next = '0;
                    end
                end
                else if (conf_hit)
                begin
                    pidx_next = pidx_reg + PCW'(1);
                    oidx_next = '0;
                end
                else
                begin
                    oidx_next = oidx_reg + OCW'(1);
                end
            end
            ST_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next     = 1'b1;
                    out_data_next      = '0;
                    out_data_next.kind = KIND_SUMMARY;
                    out_data_next.last = 1'b1;
                    if (best_v_reg)
                    begin
                        out_data_next.tag_out    = best_tag;
                        out_data_next.scheduled  = 1'b1;
                        out_data_next.row_status = best_st_reg;
                        out_data_next.bank_out   = bank_of(best_tag);
                        pend_rm   = 1'b1;
                        pcnt_next = pcnt_reg - PCW'(1);
                        ong_push  = 1'b1;
                        ocnt_next = ocnt_reg + OCW'(1);
                        bank_wr   = 1'b1;
                    end
                    cycle_next = cycle_reg + TAG_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pcnt_reg      <= '0;
            ocnt_reg      <= '0;
            oidx_reg      <= '0;
            pidx_reg      <= '0;
            best_v_reg    <= 1'b0;
            cycle_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_RST;
            phase_reg     <= BANK_RST;
            data_reg      <= DATA_RST;
            mask_reg      <= MASK_RST;
            row_open_reg  <= '0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                open_row_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            ocnt_reg      <= ocnt_next;
            oidx_reg      <= oidx_next;
            pidx_reg      <= pidx_next;
            best_v_reg    <= best_v_next;
            cycle_reg     <= cycle_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CMD:  cmd_reg   <= cfg_data[7:0];
                    CFG_BANK: phase_reg <= cfg_data[9:0];
                    CFG_DATA: data_reg  <= cfg_data[9:0];
                    CFG_MASK: mask_reg  <= cfg_data;
                    default:  mask_reg  <= mask_reg;
                endcase
            end
            if (bank_wr)
            begin
                row_open_reg[bank_of(best_tag)] <= 1'b1;
                open_row_reg[bank_of(best_tag)] <= best_tag & mask_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_st_reg  <= best_st_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/dfs_pend_cell.sv =====
// ----------------------------------------------------------------------------
// dfs_pend_cell
// One slot of the pending queue; shifts down from its neighbour on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_pend_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  dfs_pkg::dfs_cell_ctl_t      ctl,
    input  wire [dfs_pkg::TAG_W-1:0]    load_tag,
    input  wire [dfs_pkg::TAG_W-1:0]    nbr_tag,
    input  wire                         nbr_valid,
    output logic [dfs_pkg::TAG_W-1:0]   tag,
    output logic                        valid
);
    import dfs_pkg::*;

    logic [TAG_W-1:0] tag_reg;
    logic             valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tag_reg <= load_tag;
        end
        else if (ctl.shift)
        begin
            tag_reg <= nbr_tag;
        end
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== hdl/dfs_ong_cell.sv =====
// ----------------------------------------------------------------------------
// dfs_ong_cell
// One slot of the ongoing table; shifts down from its neighbour on retire.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ong_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  dfs_pkg::dfs_cell_ctl_t  ctl,
    input  dfs_pkg::dfs_ong_t       load_ent,
    input  dfs_pkg::dfs_ong_t       nbr_ent,
    input  wire                     nbr_valid,
    output dfs_pkg::dfs_ong_t       ent,
    output logic                    valid
);
    import dfs_pkg::*;

    dfs_ong_t ent_reg;
    logic     valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ent_reg <= load_ent;
        end
        else if (ctl.shift)
        begin
            ent_reg <= nbr_ent;
        end
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== hdl/dfs_conflict.sv =====
// ----------------------------------------------------------------------------
// dfs_conflict
// Window overlap check of one candidate against one ongoing request.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_conflict (
    input  wire [7:0]                   cmd_cycles,
    input  wire [9:0]                   phase_cycles,
    input  wire [9:0]                   data_cycles,
    input  wire [dfs_pkg::TAG_W-1:0]    delta,
    input  wire [1:0]                   st_o,
    input  wire [1:0]                   st_c,
    input  wire                         same_bank,
    output logic                        hit
);
    import dfs_pkg::*;

    logic [10:0]      p1;
    logic [WIN_W-1:0] os [3];
    logic [WIN_W-1:0] cs [3];
    logic [2:0]       ov;
    logic [2:0]       cv;
    logic [WIN_W-1:0] base;
    logic [WIN_W-1:0] o_be, o_ds, o_de, c_be, c_ds, c_de;
    logic             cmd_hit, data_hit, bank_hit;

    always_comb
    begin
        p1    = {1'b0, phase_cycles} + 11'd1;
        base  = WIN_W'(delta);
        os[0] = '0;
        os[1] = (st_o >= 2'd2) ? WIN_W'(p1) : '0;
        os[2] = WIN_W'(rw_off(st_o, p1));
        ov    = {1'b1, st_o >= 2'd1, st_o >= 2'd2};
        cs[0] = base;
        cs[1] = base + ((st_c >= 2'd2) ? WIN_W'(p1) : '0);
        cs[2] = base + WIN_W'(rw_off(st_c, p1));
        cv    = {1'b1, st_c >= 2'd1, st_c >= 2'd2};

        cmd_hit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (ov[i] && cv[j]
                    && os[i] <= cs[j] + WIN_W'(cmd_cycles)
                    && cs[j] <= os[i] + WIN_W'(cmd_cycles))
                begin
                    cmd_hit = 1'b1;
                end
            end
        end

        o_be = os[2] + WIN_W'(phase_cycles);
        o_ds = o_be + WIN_W'(1);
        o_de = o_ds + WIN_W'(data_cycles);
        c_be = cs[2] + WIN_W'(phase_cycles);
        c_ds = c_be + WIN_W'(1);
        c_de = c_ds + WIN_W'(data_cycles);

        data_hit = (o_ds <= c_de) && (c_ds <= o_de);
        bank_hit = same_bank && (c_be >= WIN_W'(0)) && (base <= o_be);
        hit      = cmd_hit || data_hit || bank_hit;
    end

endmodule

`default_nettype wire

// ===== hdl/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the FR-FCFS scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dram_frfcfs_scheduler_assert.svh"

module dfs_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input dfs_pkg::dfs_in_t    in_data,
    input wire                 out_valid,
    input wire                 out_stall,
    input dfs_pkg::dfs_out_t   out_data,
    input wire                 cfg_valid,
    input wire                 cfg_ready
);
    import dfs_pkg::*;

    `DFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `DFS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
    // an add answers in the next cycle with its own tag
    `DFS_ASSERT_NEXT(a_add_echo, in_valid && !in_stall && in_data.action == ACT_ADD, out_valid && out_data.tag_out == $past(in_data.tag) && out_data.last && (out_data.kind == KIND_QUEUED || out_data.kind == KIND_DROPPED), "add result missing or wrong")
    // a tick keeps the input closed while it walks the tables
    `DFS_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && in_data.action == ACT_TICK, in_stall, "input open during tick")
    `DFS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind dram_frfcfs_scheduler dfs_checker u_dfs_checker (.*);

`default_nettype wire
